// ===== hdl/ring_pixel_generator_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the ring pixel generator
// Clocked assertion wrappers, empty when the design is synthesized.
// ---------------------------------------------------------------------------
`ifndef RING_PIXEL_GENERATOR_CORE_ASSERT_SVH
`define RING_PIXEL_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// assertion that is ignored while reset is high
`define RPG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assertion that is checked during reset too
`define RPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPG_ASSERT(lbl, clk, rst, prop, msg)
`define RPG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/rpg_pkg.sv =====
// ---------------------------------------------------------------------------
// rpg_pkg
// Shared types and register codes of the ring pixel generator.
// ---------------------------------------------------------------------------
package rpg_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_STYLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THICKNESS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RING      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER     = 3'd5;

   typedef enum logic [1:0] {
      REGION_INSIDE  = 2'd0,
      REGION_RING    = 2'd1,
      REGION_OUTSIDE = 2'd2
   } region_type;

   typedef struct packed {
      logic               style;
      logic [7:0]         ring_color;
      logic [7:0]         inner_color;
      logic [7:0]         outer_color;
      logic [7:0]         cb;
      logic [7:0]         ce;
      logic [9:0]         thick;
      logic [9:0]         centre;
      logic signed [11:0] small_r;
      logic               in_ok;
      logic               out_ok;
      logic [19:0]        in_sq;
      logic [19:0]        out_sq;
   } cfg_type;

endpackage

// ===== hdl/rpg_req_if.sv =====
// ---------------------------------------------------------------------------
// rpg_req_if
// Pixel coordinate channel.
// ---------------------------------------------------------------------------
interface rpg_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] row;
   logic [9:0] col;

   modport source (output valid, output row, output col, input ready);
   modport sink (input valid, input row, input col, output ready);
endinterface

// ===== hdl/rpg_rsp_if.sv =====
// ---------------------------------------------------------------------------
// rpg_rsp_if
// Pixel value channel.
// ---------------------------------------------------------------------------
interface rpg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic [1:0] region;

   modport source (output valid, output pixel, output region, input ready);
   modport sink (input valid, input pixel, input region, output ready);
endinterface

// ===== hdl/rpg_csr.sv =====
// ---------------------------------------------------------------------------
// rpg_csr
// Configuration registers and the ring geometry derived from them.
// ---------------------------------------------------------------------------
module rpg_csr #(
   parameter int MAX_SIDE = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rpg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpg_pkg::CSR_DATA_W-1:0] csr_data,
   output rpg_pkg::cfg_type               cfg
);
   import rpg_pkg::*;

   logic        style_ff;
   logic [10:0] side_ff;
   logic [9:0]  thick_ff;
   logic [7:0]  ring_ff;
   logic [7:0]  inner_ff;
   logic [7:0]  outer_ff;
   logic [19:0] in_sq_ff, in_sq_in;
   logic [19:0] out_sq_ff, out_sq_in;

   logic [10:0]        side_c;
   logic signed [11:0] big_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff <= 1'b0;
         side_ff  <= 11'd64;
         thick_ff <= 10'd4;
         ring_ff  <= 8'd255;
         inner_ff <= 8'd0;
         outer_ff <= 8'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STYLE:     style_ff <= csr_data[0];
            CSR_SIDE:      side_ff  <= csr_data;
            CSR_THICKNESS: thick_ff <= csr_data[9:0];
            CSR_RING:      ring_ff  <= csr_data[7:0];
            CSR_INNER:     inner_ff <= csr_data[7:0];
            CSR_OUTER:     outer_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      side_c = side_ff;
      if (int'(side_ff) > MAX_SIDE) begin
         side_c = 11'(MAX_SIDE);
      end
      cfg.style       = style_ff;
      cfg.ring_color  = ring_ff;
      cfg.inner_color = inner_ff;
      cfg.outer_color = outer_ff;
      cfg.cb          = (inner_ff != 8'd0) ? inner_ff : 8'd1;
      cfg.ce          = (outer_ff != 8'd0) ? outer_ff : 8'd1;
      cfg.thick       = (thick_ff != 10'd0) ? thick_ff : 10'd1;
      cfg.centre      = side_c[10:1];
      big_r = style_ff ? $signed({2'b00, side_c[10:1]}) - 12'sd2
                       : $signed({2'b00, side_c[10:1]});
      cfg.small_r = big_r - $signed({2'b00, cfg.thick});
      cfg.in_ok   = !cfg.small_r[11];
      cfg.out_ok  = (big_r > 12'sd0);
      // squares are only read three stages into the pipe
      in_sq_in  = {10'd0, cfg.small_r[9:0]} * {10'd0, cfg.small_r[9:0]};
      out_sq_in = {10'd0, big_r[9:0]} * {10'd0, big_r[9:0]};
      cfg.in_sq  = in_sq_ff;
      cfg.out_sq = out_sq_ff;
   end

   always_ff @(posedge clock) begin
      in_sq_ff  <= in_sq_in;
      out_sq_ff <= out_sq_in;
   end

endmodule

// ===== hdl/ring_pixel_generator_core.sv =====
// ---------------------------------------------------------------------------
// ring_pixel_generator_core
// Pixel value of a circular ring, flat three-colour or linear gradient.
// ---------------------------------------------------------------------------
//  channel  | direction | word
//  req_in   | in        | row, col
//  rsp_out  | out       | pixel, region
//  csr_*    | in        | write enable, index, data
//
//  One pixel per cycle while the output is not stalled; the pipe holds the
//  one-bit-per-stage square root (FRAC_BITS + 11 stages) and the
//  eight-stage restoring divider of the blend.
//  Reset clears the valid bits and the skid-full flag; the configuration
//  registers reset to their default values.
//  A stalled output word parks in a skid register; the pipe holds while it
//  is full, so no word is lost or repeated.
`include "ring_pixel_generator_core_assert.svh"

module ring_pixel_generator_core #(
   parameter int MAX_SIDE  = 1024,
   parameter int FRAC_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   rpg_req_if.sink                        req_in,
   rpg_rsp_if.source                      rsp_out,
   input  logic                           csr_we,
   input  logic [rpg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpg_pkg::CSR_DATA_W-1:0] csr_data
);
   import rpg_pkg::*;

   localparam int RADW = 22 + 2 * FRAC_BITS;
   localparam int RTW  = 11 + FRAC_BITS;
   localparam int REMW = RTW + 2;
   localparam int SPW  = 10 + FRAC_BITS;
   localparam int NUMW = 18 + FRAC_BITS;
   localparam int DFW  = RTW + 2;
   localparam int SQ0  = 4;
   localparam int DLT  = SQ0 + RTW;
   localparam int PRD  = DLT + 1;
   localparam int ADD  = DLT + 2;
   localparam int DV0  = DLT + 3;
   localparam int OUTS = DV0 + 8;
   localparam int NS   = OUTS + 1;

   typedef struct packed {
      logic signed [10:0] dx;
      logic signed [10:0] dy;
      logic [19:0]        dx2;
      logic [19:0]        dy2;
      logic [20:0]        d2;
      region_type         region;
      logic [7:0]         pixel;
      logic [RADW-1:0]    rad;
      logic [REMW-1:0]    rem;
      logic [RTW-1:0]     root;
      logic [SPW-1:0]     delta;
      logic [NUMW-1:0]    pa;
      logic [NUMW-1:0]    pb;
      logic [NUMW-1:0]    num;
      logic [7:0]         q;
   } stage_type;

   cfg_type   cfg;
   logic [SPW-1:0] span;
   stage_type nx [NS];
   stage_type st_ff [NS];
   logic [NS-1:0] v_ff;
   logic      ena;
   logic      skid_full_ff;
   stage_type skid_ff;
   stage_type out_word;

   rpg_csr #(.MAX_SIDE(MAX_SIDE)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign span = {cfg.thick, {FRAC_BITS{1'b0}}};

   for (genvar k = 0; k < NS; k++) begin : g_stage
      if (k == 0) begin : g_in
         always_comb begin
            nx[k]    = '0;
            nx[k].dx = $signed({1'b0, req_in.row}) - $signed({1'b0, cfg.centre});
            nx[k].dy = $signed({1'b0, req_in.col}) - $signed({1'b0, cfg.centre});
         end
      end else if (k == 1) begin : g_sq
         always_comb begin
            nx[k]     = st_ff[k-1];
            nx[k].dx2 = 20'(st_ff[k-1].dx * st_ff[k-1].dx);
            nx[k].dy2 = 20'(st_ff[k-1].dy * st_ff[k-1].dy);
         end
      end else if (k == 2) begin : g_sum
         always_comb begin
            nx[k]    = st_ff[k-1];
            nx[k].d2 = {1'b0, st_ff[k-1].dx2} + {1'b0, st_ff[k-1].dy2};
         end
      end else if (k == 3) begin : g_cls
         always_comb begin
            logic is_inner;
            logic on_ring;
            is_inner = cfg.in_ok && (st_ff[k-1].d2 <= {1'b0, cfg.in_sq});
            on_ring  = !is_inner && cfg.out_ok && (st_ff[k-1].d2 < {1'b0, cfg.out_sq});
            nx[k] = st_ff[k-1];
            if (is_inner) begin
               nx[k].region = REGION_INSIDE;
               nx[k].pixel  = cfg.inner_color;
            end else if (on_ring) begin
               nx[k].region = REGION_RING;
               nx[k].pixel  = cfg.ring_color;
            end else begin
               nx[k].region = REGION_OUTSIDE;
               nx[k].pixel  = cfg.outer_color;
            end
            nx[k].rad  = {1'b0, st_ff[k-1].d2, {(2 * FRAC_BITS){1'b0}}};
            nx[k].rem  = '0;
            nx[k].root = '0;
         end
      end else if (k < DLT) begin : g_root
         // one root bit per stage
         always_comb begin
            logic [REMW+1:0] cat;
            logic [REMW+1:0] trial;
            cat   = {st_ff[k-1].rem, st_ff[k-1].rad[RADW-1 -: 2]};
            trial = {2'b00, st_ff[k-1].root, 2'b01};
            nx[k] = st_ff[k-1];
            nx[k].rad = {st_ff[k-1].rad[RADW-3:0], 2'b00};
            if (cat >= trial) begin
               nx[k].rem  = REMW'(cat - trial);
               nx[k].root = {st_ff[k-1].root[RTW-2:0], 1'b1};
            end else begin
               nx[k].rem  = cat[REMW-1:0];
               nx[k].root = {st_ff[k-1].root[RTW-2:0], 1'b0};
            end
         end
      end else if (k == DLT) begin : g_dlt
         always_comb begin
            logic signed [DFW-1:0] diff;
            logic signed [DFW-1:0] base;
            base = {cfg.small_r[11], cfg.small_r, {FRAC_BITS{1'b0}}};
            diff = $signed({2'b00, st_ff[k-1].root}) - base;
            nx[k] = st_ff[k-1];
            if (diff[DFW-1]) begin
               nx[k].delta = '0;
            end else if (diff > $signed({3'b000, span})) begin
               nx[k].delta = span;
            end else begin
               nx[k].delta = diff[SPW-1:0];
            end
         end
      end else if (k == PRD) begin : g_prd
         always_comb begin
            nx[k]    = st_ff[k-1];
            nx[k].pa = {{SPW{1'b0}}, cfg.cb} * {8'd0, span - st_ff[k-1].delta};
            nx[k].pb = {{SPW{1'b0}}, cfg.ce} * {8'd0, st_ff[k-1].delta};
         end
      end else if (k == ADD) begin : g_add
         always_comb begin
            nx[k]     = st_ff[k-1];
            nx[k].num = st_ff[k-1].pa + st_ff[k-1].pb;
            nx[k].q   = '0;
         end
      end else if (k < OUTS) begin : g_div
         // restoring step: quotient bit OUTS-1-k
         always_comb begin
            logic [NUMW-1:0] dv;
            dv    = NUMW'({8'd0, span} << (OUTS - 1 - k));
            nx[k] = st_ff[k-1];
            if (st_ff[k-1].num >= dv) begin
               nx[k].num = st_ff[k-1].num - dv;
               nx[k].q[OUTS-1-k] = 1'b1;
            end
         end
      end else begin : g_out
         always_comb begin
            nx[k] = st_ff[k-1];
            if (cfg.style && (st_ff[k-1].region == REGION_RING)) begin
               nx[k].pixel = st_ff[k-1].q;
            end
         end
      end
   end

   // the whole pipe advances unless the skid register holds a word
   assign ena          = !skid_full_ff;
   assign req_in.ready = ena;

   always_ff @(posedge clock) begin
      if (ena) begin
         for (int i = 0; i < NS; i++) begin
            st_ff[i] <= nx[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         skid_full_ff <= 1'b0;
      end else begin
         if (ena) begin
            v_ff <= {v_ff[NS-2:0], req_in.valid};
         end
         if (skid_full_ff) begin
            if (rsp_out.ready) begin
               skid_full_ff <= 1'b0;
            end
         end else if (v_ff[NS-1] && !rsp_out.ready) begin
            skid_full_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff && v_ff[NS-1] && !rsp_out.ready) begin
         skid_ff <= st_ff[NS-1];
      end
   end

   assign out_word       = skid_full_ff ? skid_ff : st_ff[NS-1];
   assign rsp_out.valid  = skid_full_ff || v_ff[NS-1];
   assign rsp_out.pixel  = out_word.pixel;
   assign rsp_out.region = out_word.region;

   `RPG_ASSERT(a_skid_shown, clock, reset, skid_full_ff |-> rsp_out.valid, "skid word not offered")
   `RPG_ASSERT(a_skid_holds, clock, reset, (skid_full_ff && !rsp_out.ready) |=> (skid_full_ff && $stable(skid_ff)), "skid word dropped")
   `RPG_ASSERT(a_no_loss, clock, reset, (v_ff[NS-1] && ena && !rsp_out.ready) |=> skid_full_ff, "stalled word not parked")
   `RPG_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !skid_full_ff, "skid not cleared by reset")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: ring pixel generator bench
// Sends pixel coordinates under a series of register settings, predicts
// each pixel value and region, and compares every result word in order.
// ---------------------------------------------------------------------------
module tb;
   import rpg_pkg::*;

   typedef struct {
      logic [9:0] row;
      logic [9:0] col;
   } coord_type;

   typedef struct {
      logic [7:0] pixel;
      region_type region;
   } shade_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_STYLE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   rpg_req_if req_bus ();
   rpg_rsp_if rsp_bus ();

   ring_pixel_generator_core dut (
      .clock(clock), .reset(reset), .req_in(req_bus), .rsp_out(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the register file
   logic       m_style;
   logic [10:0] m_side;
   logic [9:0] m_thick;
   logic [7:0] m_ring, m_inner, m_outer;

   coord_type pending_coords[$];
   shade_type expected_shades[$];
   int mismatches = 0;
   int words_seen = 0;
   int phases_run = 0;
   longint cycles = 0;
   logic req_fire = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_cnt = 0;

   function automatic longint int_sqrt(longint n);
      longint res, cand;
      res = 0;
      for (int b = 20; b >= 0; b--) begin
         cand = res | (longint'(1) << b);
         if (cand * cand <= n) res = cand;
      end
      return res;
   endfunction

   function automatic shade_type shade_of(logic [9:0] row, logic [9:0] col);
      shade_type s;
      longint side, c, t, big_r, small_r, dx, dy, d2;
      longint cb, ce, dq, span, base, delta, pix;
      bit is_inner, on_ring;
      side = (m_side > 1024) ? 1024 : m_side;
      c = side / 2;
      t = (m_thick != 0) ? m_thick : 1;
      big_r = m_style ? c - 2 : c;
      small_r = big_r - t;
      dx = longint'(row) - c;
      dy = longint'(col) - c;
      d2 = dx * dx + dy * dy;
      is_inner = (small_r >= 0) && (d2 <= small_r * small_r);
      on_ring = !is_inner && (big_r > 0) && (d2 < big_r * big_r);
      if (is_inner) begin
         s.region = REGION_INSIDE;
         s.pixel = m_inner;
      end else if (on_ring) begin
         s.region = REGION_RING;
         if (!m_style) begin
            s.pixel = m_ring;
         end else begin
            cb = (m_inner != 0) ? m_inner : 1;
            ce = (m_outer != 0) ? m_outer : 1;
            dq = int_sqrt(d2 << 16);
            span = t << 8;
            base = (small_r > 0) ? (small_r << 8) : 0;
            if (small_r < 0) delta = dq + ((-small_r) << 8);
            else delta = (dq >= base) ? dq - base : 0;
            if (delta > span) delta = span;
            pix = (cb * (span - delta) + ce * delta) / span;
            if (pix > 255) pix = 255;
            s.pixel = pix[7:0];
         end
      end else begin
         s.region = REGION_OUTSIDE;
         s.pixel = m_outer;
      end
      return s;
   endfunction

   // accept side: pop the word and predict its result
   always @(posedge clock) begin
      req_fire <= req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_shades.push_back(shade_of(req_bus.row, req_bus.col));
         void'(pending_coords.pop_front());
      end
   end

   // sender: bursts with random gaps, hold until accepted
   initial begin
      req_bus.valid = 1'b0;
      req_bus.row = '0;
      req_bus.col = '0;
   end
   always @(negedge clock) begin
      if (reset || (req_bus.valid && !req_fire)) begin
         // hold
      end else if (gap_left > 0) begin
         gap_left--;
         req_bus.valid <= 1'b0;
      end else if (pending_coords.size() > 0) begin
         req_bus.valid <= 1'b1;
         req_bus.row <= pending_coords[0].row;
         req_bus.col <= pending_coords[0].col;
         if (burst_left == 0) burst_left = $urandom_range(1, 24);
         burst_left--;
         if (burst_left == 0)
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // receiver: ready follows one of four randomly chosen stall patterns
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      stall_cnt++;
      if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= 1'($urandom_range(0, 1));
         2: rsp_bus.ready <= (stall_cnt % 4 == 0);
         default: rsp_bus.ready <= ((stall_cnt / 16) % 2 == 0);
      endcase
   end

   // monitor
   always @(posedge clock) begin
      shade_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         words_seen++;
         if (expected_shades.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: pixel %0d region %0d",
                        rsp_bus.pixel, rsp_bus.region);
         end else begin
            e = expected_shades.pop_front();
            if (rsp_bus.pixel !== e.pixel || rsp_bus.region !== e.region) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected pixel %0d region %0d, got %0d %0d",
                           e.pixel, e.region, rsp_bus.pixel, rsp_bus.region);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("timeout with %0d words still expected", expected_shades.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_STYLE:     m_style = val[0];
         CSR_SIDE:      m_side = val;
         CSR_THICKNESS: m_thick = val[9:0];
         CSR_RING:      m_ring = val[7:0];
         CSR_INNER:     m_inner = val[7:0];
         default:       m_outer = val[7:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_coord(int r, int c);
      coord_type p;
      p.row = r[9:0];
      p.col = c[9:0];
      pending_coords.push_back(p);
   endtask

   task automatic drain;
      while (pending_coords.size() > 0 || expected_shades.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   // style, side, thickness, ring, inner, outer per phase
   int ph[14][6] = '{
      '{0, 64, 4, 255, 0, 0},
      '{1, 64, 4, 255, 0, 0},
      '{0, 4, 0, 17, 200, 9},
      '{1, 4, 1, 3, 255, 255},
      '{1, 5, 0, 0, 0, 255},
      '{0, 1024, 512, 0, 255, 0},
      '{1, 1024, 512, 1, 255, 0},
      '{1, 2047, 100, 77, 0, 255},
      '{0, 2047, 1023, 170, 85, 42},
      '{1, 40, 30, 0, 10, 240},
      '{1, 100, 511, 0, 200, 20},
      '{0, 17, 3, 1, 2, 3},
      '{-1, 0, 0, 0, 0, 0},
      '{-1, 0, 0, 0, 0, 0}
   };

   initial begin
      int side, lim, c, rr;
      m_style = 0; m_side = 64; m_thick = 4; m_ring = 255; m_inner = 0; m_outer = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 14; p++) begin
         if (p > 0) begin
            if (ph[p][0] < 0) begin
               csr_write(CSR_STYLE, CSR_DATA_W'($urandom_range(0, 1)));
               csr_write(CSR_SIDE, CSR_DATA_W'($urandom_range(4, 300)));
               csr_write(CSR_THICKNESS, CSR_DATA_W'($urandom_range(0, 60)));
               csr_write(CSR_RING, CSR_DATA_W'($urandom_range(0, 255)));
               csr_write(CSR_INNER, CSR_DATA_W'($urandom_range(0, 255)));
               csr_write(CSR_OUTER, CSR_DATA_W'($urandom_range(0, 255)));
            end else begin
               csr_write(CSR_STYLE, CSR_DATA_W'(ph[p][0]));
               csr_write(CSR_SIDE, CSR_DATA_W'(ph[p][1]));
               csr_write(CSR_THICKNESS, CSR_DATA_W'(ph[p][2]));
               csr_write(CSR_RING, CSR_DATA_W'(ph[p][3]));
               csr_write(CSR_INNER, CSR_DATA_W'(ph[p][4]));
               csr_write(CSR_OUTER, CSR_DATA_W'(ph[p][5]));
            end
         end
         side = (m_side > 1024) ? 1024 : m_side;
         c = side / 2;
         rr = m_style ? c - 2 : c;
         if (p < 2) begin
            // centre, ring edges, corners of the image and of the field
            push_coord(c, c);
            push_coord(c, c + rr - ((m_thick != 0) ? m_thick : 1));
            push_coord(c, c + rr - 1);
            push_coord(c, c + rr);
            push_coord(0, 0);
            push_coord(side - 1, side - 1);
            push_coord(1023, 1023);
            push_coord(0, 1023);
            push_coord(1023, 0);
            push_coord(c + rr - 1, c);
         end
         lim = (side > 1) ? side - 1 : 0;
         for (int i = 0; i < 102; i++) begin
            if ($urandom_range(0, 6) == 0)
               push_coord($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
               push_coord($urandom_range(0, lim), $urandom_range(0, lim));
         end
         drain();
         phases_run++;
      end
      $display("covered %0d register settings, %0d result words checked, %0d mismatches",
               phases_run, words_seen, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
